// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and gated by reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Types shared by the TGA RLE decoder modules.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

   typedef enum logic [2:0] {
      ST_PIXEL  = 3'd0,
      ST_HEADER = 3'd1,
      ST_TYPE   = 3'd2,
      ST_DEPTH  = 3'd3,
      ST_BUSY   = 3'd4,
      ST_ENDED  = 3'd5
   } tga_status_type;

   typedef struct packed {
      tga_status_type status;
      logic [31:0]    pixel;
      logic [2:0]     pixel_bytes;
      logic [15:0]    width;
      logic [15:0]    height;
      logic           last_pixel;
   } tga_rsp_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } tga_buf_status_type;

endpackage

// File: hw/rtl/tga_rle_if.sv
// ----------------------------------------------------------------------------
// tga_rle_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface tga_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface tga_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] pixel;
   logic [2:0]  pixel_bytes;
   logic [15:0] width;
   logic [15:0] height;
   logic        last_pixel;

   modport source (output valid, output status, output pixel, output pixel_bytes,
                   output width, output height, output last_pixel, input ready);
   modport sink (input valid, input status, input pixel, input pixel_bytes,
                 input width, input height, input last_pixel, output ready);
endinterface

// File: hw/rtl/tga_truecolor_rle_decoder.sv
// ----------------------------------------------------------------------------
// tga_truecolor_rle_decoder
// TGA type 2 / type 10 decoder fed one byte or drain tick per beat.
//
//   channel    dir  handshake          payload
//   req_chan   in   valid/ready        mode, data_byte
//   rsp_chan   out  valid/ready        status, pixel, pixel_bytes, width,
//                                      height, last_pixel
//
// One beat per cycle while req_chan.ready is high; each beat is decoded in the
// cycle it is accepted and its result, if any, is registered for the next cycle.
// The width*height and skip products are registered; they settle by the time
// the last header byte arrives.
// Reset is synchronous; no clearing pass.
// req_chan.ready drops only while both result register and skid stage hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tga_truecolor_rle_decoder import tga_rle_pkg::*; (
   input logic     clock,
   input logic     reset,
   tga_req_if.sink req_chan,
   tga_rsp_if.source rsp_chan
);

   logic               accept;
   logic               res_valid;
   logic               space;
   tga_rsp_type        res;
   tga_rsp_type        out_data;
   tga_buf_status_type buf_status;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;

   tga_rle_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_chan.mode),
      .data_byte (req_chan.data_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   tga_rle_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .space      (space),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_data   (out_data),
      .buf_status (buf_status)
   );

   assign rsp_chan.status      = out_data.status;
   assign rsp_chan.pixel       = out_data.pixel;
   assign rsp_chan.pixel_bytes = out_data.pixel_bytes;
   assign rsp_chan.width       = out_data.width;
   assign rsp_chan.height      = out_data.height;
   assign rsp_chan.last_pixel  = out_data.last_pixel;

   `ASSERT_IMPLIES(a_skid_behind_main, clock, reset, buf_status.skid_valid,
      buf_status.main_valid)
   `ASSERT_IMPLIES(a_last_is_pixel, clock, reset, rsp_chan.valid && rsp_chan.last_pixel,
      out_data.status == ST_PIXEL)
   `ASSERT_IMPLIES(a_non_pixel_zero, clock, reset,
      rsp_chan.valid && out_data.status != ST_PIXEL, rsp_chan.pixel == 32'd0)
   `ASSERT_NEXT(a_push_lands, clock, reset, res_valid, buf_status.main_valid)

endmodule

// File: hw/rtl/tga_rle_core.sv
// ----------------------------------------------------------------------------
// tga_rle_core
// Header parser, skip counter, pixel assembler and RLE packet decoder.
// State advances on each accepted beat; the result goes out combinationally.
// ----------------------------------------------------------------------------
module tga_rle_core import tga_rle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        mode,
   input  logic [7:0]  data_byte,
   output logic        res_valid,
   output tga_rsp_type res
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_REPEAT,
      PH_DONE
   } phase_type;

   localparam logic [4:0] HDR_ID_LEN  = 5'd0;
   localparam logic [4:0] HDR_MAP     = 5'd1;
   localparam logic [4:0] HDR_KIND    = 5'd2;
   localparam logic [4:0] HDR_MAP_LO  = 5'd5;
   localparam logic [4:0] HDR_MAP_HI  = 5'd6;
   localparam logic [4:0] HDR_W_LO    = 5'd12;
   localparam logic [4:0] HDR_W_HI    = 5'd13;
   localparam logic [4:0] HDR_H_LO    = 5'd14;
   localparam logic [4:0] HDR_H_HI    = 5'd15;
   localparam logic [4:0] HDR_DEPTH   = 5'd16;
   localparam logic [4:0] HDR_LAST    = 5'd17;
   localparam logic [7:0] KIND_RAW    = 8'd2;
   localparam logic [7:0] KIND_RLE    = 8'd10;

   phase_type   phase_ff, phase_in;
   logic [4:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  id_len_ff, id_len_in;
   logic [7:0]  map_type_ff, map_type_in;
   logic [7:0]  kind_ff, kind_in;
   logic [15:0] map_len_ff, map_len_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic [23:0] skip_ff, skip_in;
   logic [31:0] pix_ff, pix_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [6:0]  pkt_left_ff, pkt_left_in;
   logic        pkt_run_ff, pkt_run_in;
   logic        await_hdr_ff, await_hdr_in;
   logic [31:0] done_cnt_ff, done_cnt_in;
   logic [31:0] total_ff, total_in;
   logic [23:0] skip_calc_ff, skip_calc_in;

   logic [2:0]  bpp;
   logic [31:0] done_next;
   logic        is_last;
   logic [31:0] pix_built;
   logic [23:0] skip_dec;
   logic [6:0]  pkt_dec;

   assign total_in     = 32'(width_ff) * 32'(height_ff);
   assign skip_calc_in = 24'(id_len_ff) + 24'(map_type_ff) * 24'(map_len_ff);

   assign bpp = (depth_ff[7:6] == 2'b00 && depth_ff[5:3] != 3'd0 && depth_ff[5:3] <= 3'd4)
                ? depth_ff[5:3] : 3'd0;
   assign done_next = done_cnt_ff + 32'd1;
   assign is_last   = (done_next >= total_ff);
   assign pix_built = ((byte_idx_ff == 2'd0) ? 32'd0 : pix_ff)
                      | (32'(data_byte) << {byte_idx_ff, 3'b000});
   assign skip_dec  = skip_ff - 24'd1;
   assign pkt_dec   = pkt_left_ff - 7'd1;

   always_comb begin
      phase_in         = phase_ff;
      hdr_cnt_in       = hdr_cnt_ff;
      id_len_in        = id_len_ff;
      map_type_in      = map_type_ff;
      kind_in          = kind_ff;
      map_len_in       = map_len_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      depth_in         = depth_ff;
      skip_in          = skip_ff;
      pix_in           = pix_ff;
      byte_idx_in      = byte_idx_ff;
      pkt_left_in      = pkt_left_ff;
      pkt_run_in       = pkt_run_ff;
      await_hdr_in     = await_hdr_ff;
      done_cnt_in      = done_cnt_ff;
      res_valid        = 1'b0;
      res.status       = ST_PIXEL;
      res.pixel        = 32'd0;
      res.pixel_bytes  = bpp;
      res.width        = width_ff;
      res.height       = height_ff;
      res.last_pixel   = 1'b0;

      if (accept) begin
         if (phase_ff == PH_DONE) begin
            res_valid  = 1'b1;
            res.status = ST_ENDED;
         end else if (mode) begin
            if (phase_ff == PH_REPEAT) begin
               pkt_left_in = pkt_dec;
               done_cnt_in = done_next;
               res_valid   = 1'b1;
               res.pixel   = pix_ff;
               if (is_last) begin
                  phase_in       = PH_DONE;
                  res.last_pixel = 1'b1;
               end else if (pkt_dec == 7'd0) begin
                  phase_in     = PH_PIXELS;
                  await_hdr_in = 1'b1;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  unique case (hdr_cnt_ff)
                     HDR_ID_LEN: id_len_in   = data_byte;
                     HDR_MAP:    map_type_in = data_byte;
                     HDR_KIND:   kind_in     = data_byte;
                     HDR_MAP_LO: map_len_in  = {map_len_ff[15:8], data_byte};
                     HDR_MAP_HI: map_len_in  = {data_byte, map_len_ff[7:0]};
                     HDR_W_LO:   width_in    = {width_ff[15:8], data_byte};
                     HDR_W_HI:   width_in    = {data_byte, width_ff[7:0]};
                     HDR_H_LO:   height_in   = {height_ff[15:8], data_byte};
                     HDR_H_HI:   height_in   = {data_byte, height_ff[7:0]};
                     HDR_DEPTH:  depth_in    = data_byte;
                     default: ;
                  endcase
                  if (hdr_cnt_ff < HDR_LAST) begin
                     hdr_cnt_in = hdr_cnt_ff + 5'd1;
                  end else begin
                     hdr_cnt_in = 5'd0;
                     res_valid  = 1'b1;
                     if (kind_ff != KIND_RAW && kind_ff != KIND_RLE) begin
                        phase_in   = PH_DONE;
                        res.status = ST_TYPE;
                     end else if (bpp == 3'd0) begin
                        phase_in   = PH_DONE;
                        res.status = ST_DEPTH;
                     end else begin
                        res.status = ST_HEADER;
                        skip_in    = skip_calc_ff;
                        if (skip_calc_ff != 24'd0) begin
                           phase_in = PH_SKIP;
                        end else begin
                           phase_in     = (total_ff == 32'd0) ? PH_DONE : PH_PIXELS;
                           await_hdr_in = 1'b1;
                           byte_idx_in  = 2'd0;
                           pix_in       = 32'd0;
                        end
                     end
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_dec == 24'd0) begin
                     phase_in     = (total_ff == 32'd0) ? PH_DONE : PH_PIXELS;
                     await_hdr_in = 1'b1;
                     byte_idx_in  = 2'd0;
                     pix_in       = 32'd0;
                  end
               end
               PH_REPEAT: begin
                  res_valid  = 1'b1;
                  res.status = ST_BUSY;
               end
               PH_PIXELS: begin
                  if (kind_ff == KIND_RLE && await_hdr_ff) begin
                     pkt_run_in   = data_byte[7];
                     pkt_left_in  = data_byte[6:0];
                     await_hdr_in = 1'b0;
                     byte_idx_in  = 2'd0;
                     pix_in       = 32'd0;
                  end else begin
                     pix_in = pix_built;
                     if ({1'b0, byte_idx_ff} + 3'd1 < bpp) begin
                        byte_idx_in = byte_idx_ff + 2'd1;
                     end else begin
                        byte_idx_in = 2'd0;
                        done_cnt_in = done_next;
                        res_valid   = 1'b1;
                        res.pixel   = pix_built;
                        if (is_last) begin
                           phase_in       = PH_DONE;
                           res.last_pixel = 1'b1;
                        end else if (kind_ff == KIND_RLE) begin
                           priority if (pkt_left_ff == 7'd0) begin
                              await_hdr_in = 1'b1;
                           end else if (pkt_run_ff) begin
                              phase_in = PH_REPEAT;
                           end else begin
                              pkt_left_in = pkt_dec;
                           end
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      total_ff     <= total_in;
      skip_calc_ff <= skip_calc_in;
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_cnt_ff   <= 5'd0;
         id_len_ff    <= 8'd0;
         map_type_ff  <= 8'd0;
         kind_ff      <= 8'd0;
         map_len_ff   <= 16'd0;
         width_ff     <= 16'd0;
         height_ff    <= 16'd0;
         depth_ff     <= 8'd0;
         skip_ff      <= 24'd0;
         pix_ff       <= 32'd0;
         byte_idx_ff  <= 2'd0;
         pkt_left_ff  <= 7'd0;
         pkt_run_ff   <= 1'b0;
         await_hdr_ff <= 1'b1;
         done_cnt_ff  <= 32'd0;
      end else begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         id_len_ff    <= id_len_in;
         map_type_ff  <= map_type_in;
         kind_ff      <= kind_in;
         map_len_ff   <= map_len_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         depth_ff     <= depth_in;
         skip_ff      <= skip_in;
         pix_ff       <= pix_in;
         byte_idx_ff  <= byte_idx_in;
         pkt_left_ff  <= pkt_left_in;
         pkt_run_ff   <= pkt_run_in;
         await_hdr_ff <= await_hdr_in;
         done_cnt_ff  <= done_cnt_in;
      end
   end

endmodule

// File: hw/rtl/tga_rle_rsp_buf.sv
// ----------------------------------------------------------------------------
// tga_rle_rsp_buf
// Result register with a skid stage; input stays open while one beat waits.
// ----------------------------------------------------------------------------
module tga_rle_rsp_buf import tga_rle_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tga_rsp_type        push_data,
   output logic               space,
   output logic               out_valid,
   input  logic               out_ready,
   output tga_rsp_type        out_data,
   output tga_buf_status_type buf_status
);

   logic        main_valid_ff, main_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   tga_rsp_type main_ff, main_in;
   tga_rsp_type skid_ff, skid_in;
   logic        main_free;

   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign main_free = !main_valid_ff || out_ready;

   assign buf_status.main_valid = main_valid_ff;
   assign buf_status.skid_valid = skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule
